/* design/wsps_pkg.sv */
`default_nettype none
package wsps_pkg;

	localparam int CORDIC_STEPS = 14;
	localparam int ANG_W = 16;
	localparam int OFS_W = 13;
	localparam int SMP_W = 16;
	localparam int ACR_W = 24;
	// Vectoring datapath width: 24-bit input scaled by 256, plus growth.
	localparam int VEC_W = 36;
	// Rotation datapath width: 16-bit sample scaled by 256, plus growth.
	localparam int ROT_W = 28;

	localparam logic [15:0] THRESHOLD_RST = 16'd36700;
	localparam logic [7:0] PLATEAU_NEED_RST = 8'd2;
	localparam logic [15:0] MIN_GAP_RST = 16'd480;
	localparam logic [15:0] FRAME_LEN_RST = 16'(540 * 80);

	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_PLATEAU_NEED = 3'd1;
	localparam logic [2:0] REG_RAW_MODE = 3'd2;
	localparam logic [2:0] REG_MIN_GAP = 3'd3;
	localparam logic [2:0] REG_FRAME_LEN = 3'd4;

	// Arctangent table in 2^-16 turns.
	function automatic logic [15:0] angle_of(input logic [3:0] idx);
		logic [15:0] a;
		begin
			case (idx)
				4'd0: a = 16'd8192;
				4'd1: a = 16'd4836;
				4'd2: a = 16'd2555;
				4'd3: a = 16'd1297;
				4'd4: a = 16'd651;
				4'd5: a = 16'd326;
				4'd6: a = 16'd163;
				4'd7: a = 16'd81;
				4'd8: a = 16'd41;
				4'd9: a = 16'd20;
				4'd10: a = 16'd10;
				4'd11: a = 16'd5;
				4'd12: a = 16'd3;
				4'd13: a = 16'd1;
				default: a = 16'd0;
			endcase
			angle_of = a;
		end
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input transaction and start CORDICs
		logic start;      // this transaction starts a frame
		logic step;       // run one CORDIC iteration
		logic finish;     // compute the scaled outputs
		logic advance;    // advance phase accumulators
		logic [3:0] iter;
	} wsps_cmd_t;

endpackage
`default_nettype wire

/* design/wsps_datapath.sv */
`default_nettype none
module wsps_datapath #(
	parameter int NUM_ANTENNAS = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wsps_pkg::wsps_cmd_t cmd,
	input wire logic raw_mode,
	input wire logic signed [15:0] s_i [2],
	input wire logic signed [15:0] s_q [2],
	input wire logic signed [23:0] a_i [2],
	input wire logic signed [23:0] a_q [2],
	output logic signed [15:0] main_i,
	output logic signed [15:0] main_q,
	output logic signed [15:0] pass_i [2],
	output logic signed [15:0] pass_q [2],
	output logic signed [12:0] offset [2]
);
	localparam int VW = wsps_pkg::VEC_W;
	localparam int RW = wsps_pkg::ROT_W;

	logic signed [VW-1:0] vx_q [2];
	logic signed [VW-1:0] vy_q [2];
	logic signed [17:0] vz_q [2];
	logic vzero_q [2];
	logic do_vec_q;
	logic signed [RW-1:0] rx_q [2];
	logic signed [RW-1:0] ry_q [2];
	logic signed [17:0] rz_q [2];
	logic signed [15:0] raw_i_q [2];
	logic signed [15:0] raw_q_q [2];
	logic [15:0] phase_q [2];
	logic signed [12:0] fofs_q [2];

	// Final scaling: floor((v*19898 + 2^22) / 2^23), saturated.
	function automatic logic signed [15:0] fin(input logic signed [RW-1:0] v);
		logic signed [RW+16:0] p;
		logic signed [RW-7:0] r;
		begin
			p = (RW+17)'(v) * (RW+17)'(signed'(17'd19898)) + (RW+17)'(signed'(24'sd4194304));
			r = p[RW+16:23];
			if (r > (RW-6)'(signed'(17'sd32767))) fin = 16'sh7fff;
			else if (r < (RW-6)'(-17'sd32768)) fin = 16'sh8000;
			else fin = r[15:0];
		end
	endfunction

	// Offset from vectoring angle: floor((z+8)/16), clamped.
	function automatic logic signed [12:0] ofs(input logic signed [17:0] z);
		logic signed [17:0] r;
		begin
			r = (z + 18'sd8) >>> 4;
			if (r > 18'sd2048) ofs = 13'sd2048;
			else if (r < -18'sd2048) ofs = -13'sd2048;
			else ofs = r[12:0];
		end
	endfunction

	// Offset latch and phase accumulators; a frame start advances by the new offset.
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [12:0] nofs;
		if (!arst_n) begin
			for (int p = 0; p < 2; p++) begin
				phase_q[p] <= '0;
				fofs_q[p] <= '0;
			end
		end else begin
			for (int p = 0; p < NUM_ANTENNAS; p++) begin
				nofs = fofs_q[p];
				if (do_vec_q) nofs = vzero_q[p] ? 13'sd0 : ofs(vz_q[p]);
				if (cmd.load && cmd.start) phase_q[p] <= '0;
				else if (cmd.advance) phase_q[p] <= phase_q[p] + 16'(nofs);
				if (cmd.finish) fofs_q[p] <= nofs;
			end
		end
	end

	// Iterative CORDIC units: one vectoring and one rotation per antenna.
	always_ff @(posedge clk) begin
		logic signed [VW-1:0] x, y;
		logic signed [RW-1:0] u, w;
		logic signed [17:0] z, a;
		logic [15:0] neg;
		if (cmd.load) begin
			do_vec_q <= cmd.start;
			for (int p = 0; p < 2; p++) begin
				x = VW'(a_i[p]) <<< 8;
				y = VW'(a_q[p]) <<< 8;
				vzero_q[p] <= (a_i[p] == 0) && (a_q[p] == 0);
				if (x < 0) begin
					vz_q[p] <= (y >= 0) ? 18'sd32768 : -18'sd32768;
					vx_q[p] <= -x;
					vy_q[p] <= -y;
				end else begin
					vz_q[p] <= '0;
					vx_q[p] <= x;
					vy_q[p] <= y;
				end
				raw_i_q[p] <= s_i[p];
				raw_q_q[p] <= s_q[p];
				u = RW'(s_i[p]) <<< 8;
				w = RW'(s_q[p]) <<< 8;
				neg = cmd.start ? 16'd0 : 16'd0 - phase_q[p];
				z = 18'(signed'(neg));
				if (z > 18'sd16384) begin
					u = -u; w = -w; z = z - 18'sd32768;
				end else if (z < -18'sd16384) begin
					u = -u; w = -w; z = z + 18'sd32768;
				end
				rx_q[p] <= u;
				ry_q[p] <= w;
				rz_q[p] <= z;
			end
		end else if (cmd.step) begin
			a = 18'(wsps_pkg::angle_of(cmd.iter));
			for (int p = 0; p < 2; p++) begin
				if (vy_q[p] >= 0) begin
					vx_q[p] <= vx_q[p] + (vy_q[p] >>> cmd.iter);
					vy_q[p] <= vy_q[p] - (vx_q[p] >>> cmd.iter);
					vz_q[p] <= vz_q[p] + a;
				end else begin
					vx_q[p] <= vx_q[p] - (vy_q[p] >>> cmd.iter);
					vy_q[p] <= vy_q[p] + (vx_q[p] >>> cmd.iter);
					vz_q[p] <= vz_q[p] - a;
				end
				if (rz_q[p] >= 0) begin
					rx_q[p] <= rx_q[p] - (ry_q[p] >>> cmd.iter);
					ry_q[p] <= ry_q[p] + (rx_q[p] >>> cmd.iter);
					rz_q[p] <= rz_q[p] - a;
				end else begin
					rx_q[p] <= rx_q[p] + (ry_q[p] >>> cmd.iter);
					ry_q[p] <= ry_q[p] - (rx_q[p] >>> cmd.iter);
					rz_q[p] <= rz_q[p] + a;
				end
			end
		end
	end

	// Output registers, loaded once the rotation finishes.
	always_ff @(posedge clk) begin
		logic signed [15:0] ri, rq;
		if (cmd.finish) begin
			for (int p = 0; p < 2; p++) begin
				ri = fin(rx_q[p]);
				rq = fin(ry_q[p]);
				if (p < NUM_ANTENNAS) begin
					pass_i[p] <= raw_mode ? raw_i_q[p] : ri;
					pass_q[p] <= raw_mode ? raw_q_q[p] : rq;
				end else begin
					pass_i[p] <= '0;
					pass_q[p] <= '0;
				end
				if (p == 0) begin
					main_i <= ri;
					main_q <= rq;
				end
			end
		end
	end

	always_comb begin
		for (int p = 0; p < 2; p++) offset[p] = (p < NUM_ANTENNAS) ? fofs_q[p] : 13'sd0;
	end
endmodule
`default_nettype wire

/* design/wsps_ctrl.sv */
`default_nettype none
module wsps_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] correlation,
	output logic out_valid,
	input wire logic out_stall,
	output logic frame_start,
	input wire logic [15:0] threshold,
	input wire logic [7:0] plateau_need,
	input wire logic [15:0] min_gap,
	input wire logic [15:0] frame_len,
	output wsps_pkg::wsps_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [3:0] iter_q;
	logic copying_q;
	logic [7:0] plat_q;
	logic [15:0] copied_q;
	logic start_q;

	logic accept, above, cp, emit, start;
	logic [7:0] plat_n;

	// Decide, for the incoming transaction, whether it emits and starts a frame.
	always_comb begin
		above = correlation > threshold;
		cp = copying_q && !(copied_q >= frame_len);
		emit = 1'b0;
		start = 1'b0;
		plat_n = plat_q;
		if (!cp) begin
			if (!above) plat_n = '0;
			else if (plat_q < plateau_need) plat_n = plat_q + 8'd1;
			else begin emit = 1'b1; start = 1'b1; end
		end else begin
			emit = 1'b1;
			if (above) begin
				if (plat_q < plateau_need) plat_n = plat_q + 8'd1;
				else if (copied_q > min_gap) start = 1'b1;
			end else plat_n = '0;
		end
		if (start) plat_n = (plateau_need > 0) ? 8'd1 : 8'd0;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign frame_start = start_q;

	always_comb begin
		cmd.load = accept && emit;
		cmd.start = start;
		cmd.step = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_FIN);
		cmd.advance = (state_q == ST_FIN);
		cmd.iter = iter_q;
	end

	// Controller state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [15:0] c;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
			copying_q <= 1'b0;
			plat_q <= '0;
			copied_q <= '0;
			start_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						plat_q <= plat_n;
						if (emit) begin
							c = start ? 16'd1 : copied_q + 16'd1;
							copied_q <= c;
							copying_q <= !(c >= frame_len);
							start_q <= start;
							iter_q <= '0;
							state_q <= ST_RUN;
						end else copying_q <= 1'b0;
					end
				end
				ST_RUN: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'(wsps_pkg::CORDIC_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/wifi_short_preamble_sync.sv */
`default_nettype none
// Channel | Handshake           | Payload
// in      | in_valid, in_stall  | correlation, antP sample and autocorrelation
// out     | out_valid, out_stall| main, pass0, pass1, frame_start, offset0/1
// cfg     | APB write/read      | threshold, plateau_need, raw_mode, min_gap, frame_len
// A transaction that produces no result is taken at once and does not stall the
// input. For one that produces a result, out_valid rises after the 14 CORDIC
// iterations, run for both antennas at once, and a finish state that loads
// the output registers. Input is stalled until the result is taken. Reset
// restores search mode and register defaults.
module wifi_short_preamble_sync #(
	parameter int NUM_ANTENNAS = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] correlation,
	input wire logic signed [15:0] ant0_sample_i,
	input wire logic signed [15:0] ant0_sample_q,
	input wire logic signed [23:0] ant0_autocorr_i,
	input wire logic signed [23:0] ant0_autocorr_q,
	input wire logic signed [15:0] ant1_sample_i,
	input wire logic signed [15:0] ant1_sample_q,
	input wire logic signed [23:0] ant1_autocorr_i,
	input wire logic signed [23:0] ant1_autocorr_q,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [15:0] main_i,
	output logic signed [15:0] main_q,
	output logic signed [15:0] pass0_i,
	output logic signed [15:0] pass0_q,
	output logic signed [15:0] pass1_i,
	output logic signed [15:0] pass1_q,
	output logic frame_start,
	output logic signed [12:0] offset0,
	output logic signed [12:0] offset1,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [15:0] threshold_q, min_gap_q, frame_len_q;
	logic [7:0] plateau_need_q;
	logic raw_mode_q;
	wsps_pkg::wsps_cmd_t cmd;
	logic signed [15:0] s_i [2], s_q [2], pi [2], pq [2];
	logic signed [23:0] a_i [2], a_q [2];
	logic signed [12:0] ofs [2];

	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wsps_pkg::THRESHOLD_RST;
			plateau_need_q <= wsps_pkg::PLATEAU_NEED_RST;
			raw_mode_q <= 1'b0;
			min_gap_q <= wsps_pkg::MIN_GAP_RST;
			frame_len_q <= wsps_pkg::FRAME_LEN_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				wsps_pkg::REG_THRESHOLD: threshold_q <= pwdata[15:0];
				wsps_pkg::REG_PLATEAU_NEED: plateau_need_q <= pwdata[7:0];
				wsps_pkg::REG_RAW_MODE: raw_mode_q <= pwdata[0];
				wsps_pkg::REG_MIN_GAP: min_gap_q <= pwdata[15:0];
				wsps_pkg::REG_FRAME_LEN: frame_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[4:2])
			wsps_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_q};
			wsps_pkg::REG_PLATEAU_NEED: prdata = {24'd0, plateau_need_q};
			wsps_pkg::REG_RAW_MODE: prdata = {31'd0, raw_mode_q};
			wsps_pkg::REG_MIN_GAP: prdata = {16'd0, min_gap_q};
			wsps_pkg::REG_FRAME_LEN: prdata = {16'd0, frame_len_q};
			default: prdata = '0;
		endcase
	end

	assign s_i[0] = ant0_sample_i;
	assign s_q[0] = ant0_sample_q;
	assign a_i[0] = ant0_autocorr_i;
	assign a_q[0] = ant0_autocorr_q;
	assign s_i[1] = ant1_sample_i;
	assign s_q[1] = ant1_sample_q;
	assign a_i[1] = ant1_autocorr_i;
	assign a_q[1] = ant1_autocorr_q;

	wsps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .correlation, .out_valid, .out_stall,
		.frame_start, .threshold(threshold_q), .plateau_need(plateau_need_q),
		.min_gap(min_gap_q), .frame_len(frame_len_q), .cmd
	);

	wsps_datapath #(.NUM_ANTENNAS(NUM_ANTENNAS)) u_dp (
		.clk, .arst_n, .cmd, .raw_mode(raw_mode_q), .s_i, .s_q, .a_i, .a_q,
		.main_i, .main_q, .pass_i(pi), .pass_q(pq), .offset(ofs)
	);

	assign pass0_i = pi[0];
	assign pass0_q = pq[0];
	assign pass1_i = pi[1];
	assign pass1_q = pq[1];
	assign offset0 = ofs[0];
	assign offset1 = ofs[1];
endmodule
`default_nettype wire
